### rtl/mfmd_pkg.sv
// Shared types and constants for the multi-turn motor feedback decoder.
`default_nettype none

package mfmd_pkg;

    // Default encoder resolution, counts per mechanical turn.
    localparam int unsigned COUNTS_PER_TURN_DEF = 8192;

    // Configuration register map.
    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned CFG_DATA_W  = 32;

    typedef logic [CFG_INDEX_W-1:0] t_cfg_index;

    localparam t_cfg_index CFG_IDX_ANGLE_GAIN = 1'd0;
    localparam t_cfg_index CFG_IDX_SPEED_GAIN = 1'd1;

    localparam logic [31:0] ANGLE_GAIN_RESET = 32'd23592960;
    localparam logic [23:0] SPEED_GAIN_RESET = 24'd6863;

    // Saturation limits of the turn counter.
    localparam logic signed [15:0] TURN_MIN = 16'sh8000;
    localparam logic signed [15:0] TURN_MAX = 16'sh7fff;

    // One raw feedback frame.
    typedef struct packed {
        logic [7:0] pos_high;
        logic [7:0] pos_low;
        logic [7:0] rpm_high;
        logic [7:0] rpm_low;
        logic [7:0] torque_high;
        logic [7:0] torque_low;
        logic [7:0] temp_byte;
    } t_in_item;

    // One decoded result.
    typedef struct packed {
        logic        [15:0] single_turn_position;
        logic signed [15:0] turns;
        logic signed [31:0] total_count;
        logic signed [47:0] angle_q16;
        logic signed [39:0] speed_q16;
        logic signed [15:0] torque_value;
        logic        [7:0]  temperature;
    } t_out_item;

    // Position unwrap result handed from the unwrap unit to the gain stage.
    typedef struct packed {
        logic        [15:0] pos;
        logic signed [15:0] turns;
        logic signed [31:0] total;
    } t_unwrap_res;

    // Contents of the middle pipeline stage.
    typedef struct packed {
        t_unwrap_res        unwrap;
        logic signed [15:0] rpm;
        logic signed [15:0] torque;
        logic        [7:0]  temp;
    } t_stage_b;

endpackage

`default_nettype wire

### rtl/mfmd_unwrap.sv
// Turn counter with position unwrap and multi-turn count formation.
`default_nettype none

module mfmd_unwrap #(
    parameter int unsigned COUNTS_PER_TURN = mfmd_pkg::COUNTS_PER_TURN_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_adv,
    input  wire logic [15:0]          i_pos,
    output mfmd_pkg::t_unwrap_res     o_res
);

    import mfmd_pkg::*;

    localparam logic signed [17:0] HALF_TURN = 18'(COUNTS_PER_TURN / 2);
    localparam logic signed [17:0] CPT       = 18'(COUNTS_PER_TURN);

    logic        [15:0] r_last;
    logic signed [15:0] r_turns;
    logic               r_primed;

    logic signed [15:0] n_turns;
    logic signed [17:0] w_delta;
    logic signed [33:0] w_total;

    assign w_delta = $signed({2'b00, i_pos}) - $signed({2'b00, r_last});

    // A jump of more than half a turn means the position wrapped.
    always_comb begin
        n_turns = r_turns;
        if (!r_primed) begin
            n_turns = '0;
        end else if (w_delta > HALF_TURN) begin
            if (r_turns != TURN_MIN) begin
                n_turns = r_turns - 16'sd1;
            end
        end else if (w_delta < -HALF_TURN) begin
            if (r_turns != TURN_MAX) begin
                n_turns = r_turns + 16'sd1;
            end
        end
    end

    assign w_total = 34'(n_turns) * 34'(CPT) + $signed({18'd0, i_pos});

    assign o_res.pos   = i_pos;
    assign o_res.turns = n_turns;
    assign o_res.total = w_total[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last   <= '0;
            r_turns  <= '0;
            r_primed <= 1'b0;
        end else if (i_adv) begin
            r_last   <= i_pos;
            r_turns  <= n_turns;
            r_primed <= 1'b1;
        end
    end

endmodule

`default_nettype wire

### rtl/motor_feedback_multiturn_decoder.sv
// Top level of the multi-turn motor feedback decoder.
// A frame is registered in stage A, then stage B, then the output register, before o_out_valid shows its result.
// Throughput: one frame per cycle while the output is not stalled; input, unwrap and gain stages then each advance.
// Reset (synchronous, active low) empties the pipeline, clears the turn state and
// the primed flag, and loads both gain registers with their default values.
`default_nettype none

module motor_feedback_multiturn_decoder #(
    parameter int unsigned COUNTS_PER_TURN = mfmd_pkg::COUNTS_PER_TURN_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // Input channel: one raw feedback frame per transaction.
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire mfmd_pkg::t_in_item                 i_in_data,
    // Output channel: one decoded result per transaction.
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output mfmd_pkg::t_out_item                     o_out_data,
    // Configuration write port.
    input  wire logic                               i_cfg_we,
    input  wire mfmd_pkg::t_cfg_index               i_cfg_index,
    input  wire logic [mfmd_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    import mfmd_pkg::*;

    // Gain registers. They must be written only while the pipeline is empty; the block does not enforce this.
    logic [31:0] r_angle_gain;
    logic [23:0] r_speed_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle_gain <= ANGLE_GAIN_RESET;
            r_speed_gain <= SPEED_GAIN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_IDX_ANGLE_GAIN: r_angle_gain <= i_cfg_data[31:0];
                CFG_IDX_SPEED_GAIN: r_speed_gain <= i_cfg_data[23:0];
                default: ;
            endcase
        end
    end

    // Pipeline occupancy. Each stage moves forward when the next stage is
    // empty or is itself moving, so a waiting result never blocks the input
    // until every stage is full.
    logic r_a_vld;
    logic r_b_vld;
    logic r_out_vld;

    logic w_out_free;
    logic w_b_adv;
    logic w_b_free;
    logic w_a_adv;
    logic w_a_free;
    logic w_in_take;

    assign w_out_free = !r_out_vld || !i_out_stall;
    assign w_b_adv    = r_b_vld && w_out_free;
    assign w_b_free   = !r_b_vld || w_b_adv;
    assign w_a_adv    = r_a_vld && w_b_free;
    assign w_a_free   = !r_a_vld || w_a_adv;
    assign w_in_take  = i_in_valid && w_a_free;

    assign o_in_stall  = !w_a_free;
    assign o_out_valid = r_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld   <= 1'b0;
            r_b_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_a_free) begin
                r_a_vld <= i_in_valid;
            end
            if (w_b_free) begin
                r_b_vld <= r_a_vld;
            end
            if (w_out_free) begin
                r_out_vld <= r_b_vld;
            end
        end
    end

    // Stage A: the raw frame as received.
    t_in_item r_a;

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_a <= i_in_data;
        end
    end

    // Unwrap: the turn state advances exactly once per frame, when that frame
    // leaves stage A, so frames are unwrapped strictly in arrival order.
    t_unwrap_res w_unwrap;

    mfmd_unwrap #(
        .COUNTS_PER_TURN(COUNTS_PER_TURN)
    ) u_unwrap (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_adv  (w_a_adv),
        .i_pos  ({r_a.pos_high, r_a.pos_low}),
        .o_res  (w_unwrap)
    );

    // Stage B: unwrapped position plus the decoded speed, torque and
    // temperature fields.
    t_stage_b r_b;

    always_ff @(posedge i_clk) begin
        if (w_b_free) begin
            r_b.unwrap <= w_unwrap;
            r_b.rpm    <= $signed({r_a.rpm_high, r_a.rpm_low});
            r_b.torque <= $signed({r_a.torque_high, r_a.torque_low});
            r_b.temp   <= r_a.temp_byte;
        end
    end

    // Gain stage: two independent multiplies. The angle is the multi-turn
    // count times the Q32 gain, shifted right by 16 with floor rounding,
    // which leaves degrees in Q16. The speed is the signed rpm times the
    // Q16 gain, exact.
    logic signed [64:0] w_angle_prod;
    logic signed [40:0] w_speed_prod;

    assign w_angle_prod = 65'(r_b.unwrap.total) * $signed({33'd0, r_angle_gain});
    assign w_speed_prod = 41'(r_b.rpm) * $signed({17'd0, r_speed_gain});

    t_out_item r_out;

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            r_out.single_turn_position <= r_b.unwrap.pos;
            r_out.turns                <= r_b.unwrap.turns;
            r_out.total_count          <= r_b.unwrap.total;
            r_out.angle_q16            <= w_angle_prod[63:16];
            r_out.speed_q16            <= w_speed_prod[39:0];
            r_out.torque_value         <= r_b.torque;
            r_out.temperature          <= r_b.temp;
        end
    end

    assign o_out_data = r_out;

endmodule

`default_nettype wire

### sim/tb.sv
// Self-checking testbench for the multi-turn motor feedback decoder.

module tb;

    import mfmd_pkg::*;

    localparam int          CPT          = int'(COUNTS_PER_TURN_DEF);
    localparam int          HALF_TURN    = CPT / 2;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          HOLD_CYCLES  = 150;
    localparam int          WALK_TURNS   = 40;
    localparam int unsigned CYCLE_LIMIT  = 2_000_000;

    // Clock, reset and block inputs, all known from time zero.
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    t_in_item              i_in_data   = '0;
    logic                  i_out_stall = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    t_cfg_index            i_cfg_index = CFG_IDX_ANGLE_GAIN;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    logic                  o_in_stall;
    logic                  o_out_valid;
    t_out_item             o_out_data;

    // Decoder state as the testbench tracks it.
    logic [15:0]        track_pos    = '0;
    logic signed [15:0] turn_acc     = '0;
    logic               track_primed = 1'b0;
    logic [31:0]        gain_angle   = ANGLE_GAIN_RESET;
    logic [23:0]        gain_speed   = SPEED_GAIN_RESET;

    // Decoded frames still owed by the block, oldest first.
    t_out_item predicted_decodes[$];

    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;

    // Sender pacing.
    logic tx_active  = 1'b0;
    int   burst_left = 0;

    // Receiver stall pattern and long hold-off requests.
    logic       rx_quiet      = 1'b0;
    int         hold_asked    = 0;
    int         hold_served   = 0;
    int         hold_left     = 0;
    int         stall_mode    = 0;
    int         mode_left     = 0;
    logic [7:0] stall_pattern = 8'b0;

    motor_feedback_multiturn_decoder #(
        .COUNTS_PER_TURN(CPT)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Unwraps one frame against the tracked state and forms the decoded result.
    function automatic t_out_item decode_frame(t_in_item f);
        logic [15:0]        pos;
        logic signed [15:0] rpm;
        int                 delta;
        longint             total;
        longint             angle_full;
        longint             speed_full;
        t_out_item          res;
        pos   = {f.pos_high, f.pos_low};
        rpm   = {f.rpm_high, f.rpm_low};
        delta = int'(pos) - int'(track_pos);
        if (!track_primed) begin
            // The first frame after reset defines turn zero.
            turn_acc     = '0;
            track_primed = 1'b1;
        end else if (delta > HALF_TURN) begin
            if (turn_acc != TURN_MIN) turn_acc = turn_acc - 16'sd1;
        end else if (delta < -HALF_TURN) begin
            if (turn_acc != TURN_MAX) turn_acc = turn_acc + 16'sd1;
        end
        track_pos = pos;

        total      = longint'(turn_acc) * CPT + longint'(pos);
        angle_full = (total * longint'(gain_angle)) >>> 16;
        speed_full = longint'(rpm) * longint'(gain_speed);

        res.single_turn_position = pos;
        res.turns                = turn_acc;
        res.total_count          = total[31:0];
        res.angle_q16            = angle_full[47:0];
        res.speed_q16            = speed_full[39:0];
        res.torque_value         = {f.torque_high, f.torque_low};
        res.temperature          = f.temp_byte;
        return res;
    endfunction

    function automatic t_in_item make_frame(logic [15:0] pos, logic [15:0] rpm,
                                            logic [15:0] trq, logic [7:0] temp);
        return {pos, rpm, trq, temp};
    endfunction

    // Mostly smooth motion around the wrap thresholds, with some wild jumps.
    function automatic t_in_item random_frame();
        int kind;
        int p;
        int d;
        kind = int'($urandom_range(0, 99));
        if (kind < 55) begin
            p = (int'(track_pos) % CPT + int'($urandom_range(0, 2400)) - 1200 + CPT) % CPT;
        end else if (kind < 75) begin
            d = HALF_TURN - 1 + int'($urandom_range(0, 2));
            if ($urandom_range(0, 1) == 1) d = -d;
            p = int'(track_pos) + d;
            if (p < 0 || p > 65535) p = int'(track_pos) - d;
        end else if (kind < 90) begin
            p = int'($urandom_range(0, CPT - 1));
        end else begin
            p = int'($urandom_range(0, 65535));
        end
        return make_frame(p[15:0], 16'($urandom), 16'($urandom), 8'($urandom));
    endfunction

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatch_count++;
        end
    endtask

    // Offers one frame and holds it until the block takes the transaction.
    task automatic send_frame(t_in_item f);
        i_in_valid <= 1'b1;
        i_in_data  <= f;
        tx_active = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        predicted_decodes.push_back(decode_frame(f));
    endtask

    task automatic stop_offering();
        if (tx_active) begin
            i_in_valid <= 1'b0;
            tx_active = 1'b0;
        end
    endtask

    // Bursts of random length separated by random gaps.
    task automatic pace();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            stop_offering();
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 9) == 0) ? int'($urandom_range(40, 120))
                                                     : int'($urandom_range(0, 12));
        end
    endtask

    task automatic wait_drained();
        stop_offering();
        while (predicted_decodes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_index idx, logic [CFG_DATA_W-1:0] data);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_IDX_ANGLE_GAIN) gain_angle = data;
        else gain_speed = data[23:0];
    endtask

    // Field extremes and each unwrap case, back to back with the reset gains.
    task automatic test_directed();
        send_frame(make_frame(16'd1000, 16'h0000, 16'h0000, 8'h00)); // first frame
        send_frame(make_frame(16'd0,    16'h7fff, 16'h7fff, 8'hff));
        send_frame(make_frame(16'd8191, 16'h8000, 16'h8000, 8'h00)); // backward wrap
        send_frame(make_frame(16'd0,    16'hffff, 16'hffff, 8'h80)); // forward wrap
        send_frame(make_frame(16'd4096, 16'h0001, 16'h0001, 8'h01)); // exactly half: none
        send_frame(make_frame(16'd0,    16'hfffe, 16'h8001, 8'h7f)); // minus half: none
        send_frame(make_frame(16'd4097, 16'h00ff, 16'hff00, 8'hfe)); // just past half
        send_frame(make_frame(16'd0,    16'hff00, 16'h00ff, 8'h55)); // just past minus half
        send_frame(make_frame(16'hffff, 16'h5555, 16'haaaa, 8'haa)); // beyond one turn
        send_frame(make_frame(16'd8192, 16'haaaa, 16'h5555, 8'h33));
        send_frame(make_frame(16'd12000, 16'h1234, 16'hedcb, 8'hcc));
        send_frame(make_frame(16'hff00, 16'h8000, 16'h7fff, 8'hff));
        send_frame(make_frame(16'h00ff, 16'h7fff, 16'h8000, 8'h00));
        send_frame(make_frame(16'd4000, 16'h0000, 16'h0000, 8'h00));
        wait_drained();
    endtask

    // Random frames over several gain settings, extremes included.
    task automatic test_random_gains();
        logic [31:0] a;
        logic [31:0] s;
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                1: begin a = '0;           s = '0;          end
                2: begin a = '1;           s = '1;          end
                3: begin a = $urandom;     s = $urandom_range(0, 32'hff_ffff); end
                4: begin a = 32'd1;        s = 32'd1;       end
                5: begin a = $urandom;     s = $urandom;    end
                6: begin a = 32'h8000_0000; s = 32'h0080_0000; end
                default: begin a = ANGLE_GAIN_RESET; s = 32'(SPEED_GAIN_RESET); end
            endcase
            // The first phase runs on the values loaded by reset.
            if (phase != 0) begin
                write_reg(CFG_IDX_ANGLE_GAIN, a);
                write_reg(CFG_IDX_SPEED_GAIN, s);
            end
            repeat (160) begin
                send_frame(random_frame());
                pace();
            end
        end
        wait_drained();
    endtask

    // The receiver holds off long enough for the pipeline to fill and stall the input.
    task automatic test_output_hold();
        wait_drained();
        hold_asked <= hold_asked + 1;
        repeat (60) send_frame(random_frame());
        wait_drained();
    endtask

    // Long runs of wraps in one direction and then the other with the largest gains,
    // so the turn count moves well away from zero on both sides.
    task automatic test_turn_limits();
        int x;
        write_reg(CFG_IDX_ANGLE_GAIN, '1);
        write_reg(CFG_IDX_SPEED_GAIN, 32'h00ff_ffff);
        rx_quiet <= 1'b1;

        // Each drop of just over half a turn adds a turn; the climb back adds none.
        x = 61000;
        send_frame(make_frame(x[15:0], 16'($urandom), 16'($urandom), 8'($urandom)));
        repeat (WALK_TURNS) begin
            send_frame(make_frame(16'(x - 4097), 16'($urandom), 16'($urandom), 8'($urandom)));
            send_frame(make_frame(16'(x - 1), 16'($urandom), 16'($urandom), 8'($urandom)));
            x--;
            if (x < 4200) begin
                send_frame(make_frame(16'(x + 4096), 16'($urandom), 16'($urandom),
                                      8'($urandom)));
                x += 4096;
            end
        end

        // Mirror image, twice as far: a rise of just over half a turn removes a turn.
        x = 4000;
        send_frame(make_frame(x[15:0], 16'($urandom), 16'($urandom), 8'($urandom)));
        repeat (2 * WALK_TURNS) begin
            send_frame(make_frame(16'(x + 4097), 16'($urandom), 16'($urandom), 8'($urandom)));
            send_frame(make_frame(16'(x + 1), 16'($urandom), 16'($urandom), 8'($urandom)));
            x++;
            if (x > 61000) begin
                send_frame(make_frame(16'(x - 4096), 16'($urandom), 16'($urandom),
                                      8'($urandom)));
                x -= 4096;
            end
        end
        wait_drained();
        rx_quiet <= 1'b0;

        repeat (40) begin
            send_frame(random_frame());
            pace();
        end
        wait_drained();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random_gains();
        test_output_hold();
        test_turn_limits();
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Receiver: long hold-offs on request, no stall while quiet or in reset, otherwise a
    // stall pattern that changes character whenever a randomly chosen mode length runs out.
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (hold_served != hold_asked) begin
            hold_served <= hold_asked;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (rx_quiet || !i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                stall_mode    <= int'($urandom_range(0, 3));
                mode_left     <= int'($urandom_range(8, 64));
                stall_pattern <= 8'($urandom);
            end else begin
                mode_left     <= mode_left - 1;
                stall_pattern <= {stall_pattern[6:0], stall_pattern[7]};
            end
            case (stall_mode)
                1:       i_out_stall <= ($urandom_range(0, 3) == 0);
                2:       i_out_stall <= ($urandom_range(0, 3) != 0);
                3:       i_out_stall <= stall_pattern[0];
                default: i_out_stall <= 1'b0;
            endcase
        end
    end

    // Every accepted result is matched against the oldest prediction.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (predicted_decodes.size() == 0) begin
                $error("result transaction with no frame outstanding");
                mismatch_count++;
            end else begin
                want = predicted_decodes.pop_front();
                check_field("single_turn_position", want.single_turn_position,
                            o_out_data.single_turn_position);
                check_field("turns", want.turns, o_out_data.turns);
                check_field("total_count", want.total_count, o_out_data.total_count);
                check_field("angle_q16", want.angle_q16, o_out_data.angle_q16);
                check_field("speed_q16", want.speed_q16, o_out_data.speed_q16);
                check_field("torque_value", want.torque_value, o_out_data.torque_value);
                check_field("temperature", want.temperature, o_out_data.temperature);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

endmodule

### filelist.f
rtl/mfmd_pkg.sv
rtl/mfmd_unwrap.sv
rtl/motor_feedback_multiturn_decoder.sv
sim/tb.sv
